>>> sv/spr_pkg.sv
// Shared types, SLIP codes and sizes for the SLIP packet receiver.
package spr_pkg;

    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    localparam int MAX_RAW_BYTES_DEF = 64;
    localparam int IDX_W    = 6;
    localparam int RAW_W    = 7;
    localparam int LEN_W    = 6;
    localparam int ADDR_W   = IDX_W + 1;
    localparam int MAX_LEN  = (1 << LEN_W) - 1;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } spr_wr_t;

    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
    } spr_desc_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_SHOW
    } back_state_t;

endpackage

>>> sv/spr_front.sv
// Front end: SLIP decoding of raw bytes into the packet buffer and packet framing.
module spr_front #(
    parameter int MAX_RAW_BYTES = spr_pkg::MAX_RAW_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    output spr_pkg::spr_wr_t  wr,
    output logic              push,
    output spr_pkg::spr_desc_t push_desc,
    input  logic              q_full
);
    import spr_pkg::*;

    logic             receiving_reg, receiving_next;
    logic [RAW_W-1:0] raw_count_reg, raw_count_next;
    logic             escape_reg, escape_next;
    logic [RAW_W-1:0] dcount_reg, dcount_next;
    logic             bank_reg, bank_next;
    logic             accept;
    logic             store_en;
    logic [7:0]       store_val;
    logic [RAW_W-1:0] dcount_base;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        receiving_next = receiving_reg;
        raw_count_next = raw_count_reg;
        escape_next    = escape_reg;
        dcount_base    = dcount_reg;
        bank_next      = bank_reg;
        store_en       = 1'b0;
        store_val      = rx_byte;
        push           = 1'b0;
        push_desc.bank = bank_reg;
        push_desc.len  = (dcount_reg > RAW_W'(MAX_LEN)) ? LEN_W'(MAX_LEN)
                                                         : dcount_reg[LEN_W-1:0];
        if (accept)
        begin
            if (!receiving_reg)
            begin
                if (rx_byte != SLIP_END)
                begin
                    // First byte of a packet: restart counters, then decode it.
                    receiving_next = 1'b1;
                    raw_count_next = RAW_W'(1);
                    dcount_base    = '0;
                    escape_next    = (rx_byte == SLIP_ESC);
                    store_en       = (rx_byte != SLIP_ESC);
                end
            end
            else if (raw_count_reg >= RAW_W'(MAX_RAW_BYTES))
            begin
                // Overlong packet is dropped along with this byte.
                receiving_next = 1'b0;
            end
            else if (rx_byte != SLIP_END)
            begin
                raw_count_next = raw_count_reg + RAW_W'(1);
                if (escape_reg)
                begin
                    escape_next = 1'b0;
                    if (rx_byte == SLIP_ESC_END)
                    begin
                        store_en  = 1'b1;
                        store_val = SLIP_END;
                    end
                    else if (rx_byte == SLIP_ESC_ESC)
                    begin
                        store_en  = 1'b1;
                        store_val = SLIP_ESC;
                    end
                end
                else if (rx_byte == SLIP_ESC)
                begin
                    escape_next = 1'b1;
                end
                else
                begin
                    store_en = 1'b1;
                end
            end
            else
            begin
                // End of packet: hand the filled bank to the back end.
                receiving_next = 1'b0;
                escape_next    = 1'b0;
                push           = 1'b1;
                bank_next      = ~bank_reg;
            end
        end
        dcount_next = store_en ? dcount_base + RAW_W'(1) : dcount_base;
        wr.en       = store_en;
        wr.addr     = {bank_reg, dcount_base[IDX_W-1:0]};
        wr.data     = store_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg <= 1'b0;
            raw_count_reg <= '0;
            escape_reg    <= 1'b0;
            dcount_reg    <= '0;
            bank_reg      <= 1'b0;
        end
        else
        begin
            receiving_reg <= receiving_next;
            raw_count_reg <= raw_count_next;
            escape_reg    <= escape_next;
            dcount_reg    <= dcount_next;
            bank_reg      <= bank_next;
        end
    end

    a_write_keeps_packet: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |=> receiving_reg)
        else $error("buffer write did not leave the packet open");
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("packet pushed into a full queue");
    a_raw_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        raw_count_reg <= RAW_W'(MAX_RAW_BYTES))
        else $error("raw count ran past the limit");

endmodule

>>> sv/spr_queue.sv
// Two-entry queue of finished packet descriptors between front and back end.
module spr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  spr_pkg::spr_desc_t push_desc,
    input  logic               pop,
    output logic               q_valid,
    output logic               q_full,
    output spr_pkg::spr_desc_t head
);
    import spr_pkg::*;

    spr_desc_t   entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign q_valid = (count_reg != 2'd0);
    assign q_full  = (count_reg == 2'd2);
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != 2'd0))
        else $error("queue underflow");

endmodule

>>> sv/spr_back.sv
// Back end: two-bank packet buffer and the drain that sends out decoded words.
module spr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  spr_pkg::spr_wr_t   wr,
    input  logic               q_valid,
    input  spr_pkg::spr_desc_t head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         data_byte,
    output logic               last_byte,
    output logic               empty_packet,
    output logic [spr_pkg::LEN_W-1:0] packet_length
);
    import spr_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [7:0]       mem [DEPTH];
    logic [7:0]       rd_data_reg;
    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             rd_en;
    logic             is_empty;
    logic             is_last;
    logic             done;

    assign is_empty = (head.len == '0);
    assign is_last  = is_empty || (idx_reg == IDX_W'(head.len - LEN_W'(1)));
    assign done     = out_valid && out_ready && is_last;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[{head.bank, idx_reg}];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            B_IDLE:
            begin
                idx_next = '0;
                if (q_valid)
                begin
                    state_next = is_empty ? B_SHOW : B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_SHOW;
            end
            B_SHOW:
            begin
                if (out_ready)
                begin
                    if (is_last)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_en     = 1'b0;
        out_valid = 1'b0;
        pop       = 1'b0;
        case (state_reg)
            B_READ:
            begin
                rd_en = 1'b1;
            end
            B_SHOW:
            begin
                out_valid = 1'b1;
                pop       = out_ready && is_last;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign data_byte     = is_empty ? 8'd0 : rd_data_reg;
    assign last_byte     = is_last;
    assign empty_packet  = is_empty;
    assign packet_length = head.len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    a_show_has_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != B_IDLE) |-> q_valid)
        else $error("drain active without a queued packet");
    a_read_then_show: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_READ) |=> (state_reg == B_SHOW))
        else $error("buffer read not followed by an output word");
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (state_reg == B_IDLE))
        else $error("drain continued past the last word");

endmodule

>>> sv/slip_packet_receiver_core.sv
// Top level of the SLIP packet receiver: front decoder, descriptor queue, buffered drain.
//
//   Channel   Direction  Handshake             Word
//   rx        in         in_valid / in_ready   rx_byte
//   result    out        out_valid / out_ready data_byte, last_byte, empty_packet,
//                                              packet_length
//
// The front end takes one raw word per cycle and decodes it straight into one of
// two 64-byte buffer banks; it only stalls when both banks hold packets that are
// still waiting to be drained. The drain reads each word from the buffer, then
// shows it until it is taken, and returns to idle between packets. Reset clears
// all control state; the buffer needs no clearing pass. Either side may stall
// indefinitely without losing or repeating words.
module slip_packet_receiver_core #(
    parameter int MAX_RAW_BYTES = spr_pkg::MAX_RAW_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       last_byte,
    output logic       empty_packet,
    output logic [spr_pkg::LEN_W-1:0] packet_length
);
    import spr_pkg::*;

    // Decoded bytes travel from front to back through the buffer write port,
    // while the queue carries which bank is complete and how long it is.
    spr_wr_t   wr;
    spr_desc_t push_desc;
    spr_desc_t head;
    logic      push;
    logic      pop;
    logic      q_valid;
    logic      q_full;

    spr_front #(
        .MAX_RAW_BYTES (MAX_RAW_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .wr        (wr),
        .push      (push),
        .push_desc (push_desc),
        .q_full    (q_full)
    );

    spr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_full    (q_full),
        .head      (head)
    );

    // The drain works on the packet at the head of the queue and pops it once
    // its last word has been taken.
    spr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr            (wr),
        .q_valid       (q_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .empty_packet  (empty_packet),
        .packet_length (packet_length)
    );

endmodule
